// ===== design/polyvd_pkg.sv =====
package polyvd_pkg;

    // sizes of the coefficient store and the fixed-point format
    localparam int MAX_DEGREE = 15;
    localparam int IDX_W      = 4;
    localparam int DATA_W     = 32;
    localparam int Q_FRAC     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int STORE_DEPTH = MAX_DEGREE + 1;

    // 1.0 in Q16.16
    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1) <<< Q_FRAC;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_EVAL  = 2'd1,
        CMD_DERIV = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WT,
        S_WT1,
        S_WT2,
        S_PROD,
        S_POW,
        S_ACC,
        S_PW
    } state_t;

    typedef struct packed {
        command_t                 command;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] operand;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        status_t                  status;
    } result_t;

    // request to the shared multiplier
    typedef struct packed {
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic                     frac;
    } mul_req_t;

endpackage

// ===== design/polyvd_store.sv =====
module polyvd_store (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [polyvd_pkg::IDX_W-1:0]          wr_addr,
    input  logic signed [polyvd_pkg::DATA_W-1:0]  wr_data,
    input  logic [polyvd_pkg::IDX_W-1:0]          rd_addr,
    output logic signed [polyvd_pkg::DATA_W-1:0]  rd_data
);
    import polyvd_pkg::*;

    logic signed [DATA_W-1:0] coef_reg [STORE_DEPTH];

    // coefficient registers, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            coef_reg[wr_addr] <= wr_data;
        end
    end

    // single read port
    assign rd_data = coef_reg[rd_addr];

endmodule

// ===== design/polyvd_mul.sv =====
module polyvd_mul (
    input  logic                                  clk,
    input  polyvd_pkg::mul_req_t                  req,
    output logic signed [polyvd_pkg::DATA_W-1:0]  prod,
    output logic                                  sat
);
    import polyvd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     frac_reg;
    logic signed [PROD_W-1:0] shifted;
    logic                     ovf;
    logic signed [DATA_W-1:0] res_reg;
    logic signed [DATA_W-1:0] res_next;
    logic                     sat_reg;

    // stage one: full product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
        frac_reg <= req.frac;
    end

    // floor shift for q16.16 when frac is set, then clamp to 32 bits
    always_comb
    begin
        shifted  = frac_reg ? (prod_reg >>> Q_FRAC) : prod_reg;
        ovf      = (shifted[PROD_W-1:DATA_W-1] != '0) && (shifted[PROD_W-1:DATA_W-1] != '1);
        res_next = shifted[DATA_W-1:0];
        if (ovf)
        begin
            res_next = shifted[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // stage two: clamped result
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        sat_reg <= ovf;
    end

    assign prod = res_reg;
    assign sat  = sat_reg;

endmodule

// ===== design/polynomial_value_and_derivative_unit.sv =====
// Polynomial value and derivative unit, signed Q16.16.
// Command channel: a command is accepted at a rising edge with start high and
// busy low. Load writes a coefficient and echoes it, read returns one
// coefficient (status 1 above the degree), evaluate returns sum c_i*x^i and
// derivative returns sum (i+1)*c_(i+1)*x^i; saturation gives status 2.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver must take it then, there is no stall.
// Configuration: cfg_we writes cfg_data into the degree register at once.
// Timing: load and read finish in the cycle after transfer, busy stays low,
// so they may issue every cycle. Evaluate runs one sequencer pass per term for
// d+1 terms, derivative for d terms (d = degree in use; at d = 0 it answers like a read).
// The per-term cost is set by the one shared two-stage multiplier: each term
// needs the product with the running power and the next power of x, and the
// derivative also forms its weight (i+1)*c on that multiplier first.
// Reset clears the coefficient store, the degree and the sequencer.
module polynomial_value_and_derivative_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  polyvd_pkg::cmd_t                   cmd,
    output logic                               done,
    output polyvd_pkg::result_t                result,
    input  logic                               cfg_we,
    input  logic [polyvd_pkg::IDX_W-1:0]       cfg_data
);
    import polyvd_pkg::*;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         deg_reg;
    logic [IDX_W-1:0]         deg_use;
    logic [IDX_W-1:0]         term_reg, term_next;
    logic                     deriv_reg, deriv_next;
    logic                     sat_reg, sat_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] pw_reg, pw_next;
    logic signed [DATA_W-1:0] w_reg, w_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    result_t                  out_reg, out_next;
    logic                     done_reg, done_next;

    logic                     accept;
    logic                     more;
    logic [IDX_W-1:0]         term_addr;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     wr_en;
    logic                     load_ok;
    mul_req_t                 mreq;
    logic signed [DATA_W-1:0] mprod;
    logic                     msat;
    logic [DATA_W:0]          sum;
    logic                     add_ovf;
    logic signed [DATA_W-1:0] sum_sat;

    assign accept  = start && !busy;
    assign busy    = (state_reg != S_IDLE);
    assign deg_use = (32'(deg_reg) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE) : deg_reg;
    assign load_ok = (32'(cmd.index) <= MAX_DEGREE);

    // another term follows the current one
    assign more = deriv_reg ? (({1'b0, term_reg} + 1'b1) < {1'b0, deg_use})
                            : (term_reg < deg_use);

    assign term_addr = deriv_reg ? (term_reg + 1'b1) : term_reg;
    assign rd_addr   = (state_reg == S_IDLE) ? cmd.index : term_addr;
    assign wr_en     = accept && (cmd.command == CMD_LOAD) && load_ok;

    polyvd_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (cmd.index),
        .wr_data (cmd.operand),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    polyvd_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (mprod),
        .sat  (msat)
    );

    // saturating add of the product into the accumulator
    always_comb
    begin
        sum     = {acc_reg[DATA_W-1], acc_reg} + {mprod[DATA_W-1], mprod};
        add_ovf = (sum[DATA_W] != sum[DATA_W-1]);
        sum_sat = sum[DATA_W-1:0];
        if (add_ovf)
        begin
            sum_sat = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.command == CMD_EVAL))
                begin
                    state_next = S_PROD;
                end
                else if (accept && (cmd.command == CMD_DERIV) && (deg_use != '0))
                begin
                    state_next = S_WT;
                end
            end
            S_WT:   state_next = S_WT1;
            S_WT1:  state_next = S_WT2;
            S_WT2:  state_next = S_PROD;
            S_PROD: state_next = S_POW;
            S_POW:  state_next = S_ACC;
            S_ACC:  state_next = S_PW;
            S_PW:
            begin
                if (!more)
                begin
                    state_next = S_IDLE;
                end
                else if (deriv_reg)
                begin
                    state_next = S_WT;
                end
                else
                begin
                    state_next = S_PROD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // multiplier requests and datapath updates
    always_comb
    begin
        mreq       = '0;
        term_next  = term_reg;
        deriv_next = deriv_reg;
        sat_next   = sat_reg;
        x_next     = x_reg;
        pw_next    = pw_reg;
        w_next     = w_reg;
        acc_next   = acc_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    term_next  = '0;
                    deriv_next = (cmd.command == CMD_DERIV);
                    sat_next   = 1'b0;
                    x_next     = cmd.operand;
                    pw_next    = Q_ONE;
                    acc_next   = '0;
                    case (cmd.command)
                        CMD_LOAD:
                        begin
                            done_next = 1'b1;
                            out_next.result_value = load_ok ? cmd.operand : '0;
                            out_next.status       = load_ok ? ST_OK : ST_RANGE;
                        end
                        CMD_READ:
                        begin
                            done_next = 1'b1;
                            out_next.result_value = (cmd.index > deg_use) ? '0 : rd_data;
                            out_next.status       = (cmd.index > deg_use) ? ST_RANGE : ST_OK;
                        end
                        CMD_DERIV:
                        begin
                            // derivative of a constant is zero
                            if (deg_use == '0)
                            begin
                                done_next = 1'b1;
                                out_next.result_value = '0;
                                out_next.status       = ST_OK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WT:
            begin
                // weight (i+1)*c(i+1), plain integer product
                mreq.a    = DATA_W'({1'b0, term_reg} + 1'b1);
                mreq.b    = rd_data;
                mreq.frac = 1'b0;
            end
            S_WT2:
            begin
                w_next   = mprod;
                sat_next = sat_reg | msat;
            end
            S_PROD:
            begin
                mreq.a    = pw_reg;
                mreq.b    = deriv_reg ? w_reg : rd_data;
                mreq.frac = 1'b1;
            end
            S_POW:
            begin
                mreq.a    = pw_reg;
                mreq.b    = x_reg;
                mreq.frac = 1'b1;
            end
            S_ACC:
            begin
                acc_next = sum_sat;
                sat_next = sat_reg | msat | add_ovf;
            end
            S_PW:
            begin
                if (more)
                begin
                    // power advances only when a later term uses it
                    pw_next   = mprod;
                    sat_next  = sat_reg | msat;
                    term_next = term_reg + 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                    out_next.result_value = acc_reg;
                    out_next.status       = sat_reg ? ST_SAT : ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            deg_reg   <= '0;
            done_reg  <= 1'b0;
            term_reg  <= '0;
            deriv_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            term_reg  <= term_next;
            deriv_reg <= deriv_next;
            sat_reg   <= sat_next;
            if (cfg_we)
            begin
                deg_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        pw_reg  <= pw_next;
        w_reg   <= w_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign done   = done_reg;
    assign result = out_reg;

    // a result only appears once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer active");

    // load and read answer in the next cycle
    a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((cmd.command == CMD_LOAD) || (cmd.command == CMD_READ))) |=> done_reg)
        else $error("load or read result missing");

    // range status only follows a load or read transfer
    a_range_src: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (out_reg.status == ST_RANGE)) |->
        $past(accept && ((cmd.command == CMD_LOAD) || (cmd.command == CMD_READ))))
        else $error("range status without load or read");

    // evaluation always occupies the sequencer
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.command == CMD_EVAL)) |=> (busy && !done_reg))
        else $error("evaluation did not start");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import polyvd_pkg::*;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    cmd_t    cmd_word = '0;
    logic    done;
    result_t result_word;
    logic    cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_data = '0;

    // commands waiting to be sent, answers waiting to come back
    cmd_t    pending_cmds[$];
    result_t answers_due[$];

    // mirror of the block state
    logic signed [DATA_W-1:0] coef_mem[STORE_DEPTH];
    logic [IDX_W-1:0]         deg_cfg;

    bit      gaps_on;
    bit      drain_hold;
    result_t next_answer;
    result_t got_answer;
    int      err_count;
    int      cmd_tally[4];
    int      sat_tally;
    int      range_tally;
    logic [15:0] degrees_used;

    polynomial_value_and_derivative_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd_word),
        .done     (done),
        .result   (result_word),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // clock
    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        if (err_count < 100)
            $display("tb_top: mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // saturate a wide value to 32 bits
    function automatic logic signed [DATA_W-1:0] clamp32(input longint v, inout bit ovf);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            ovf = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -longint'(64'sh8000_0000))
        begin
            ovf = 1'b1;
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // q16.16 product, floor rounding, saturated
    function automatic logic signed [DATA_W-1:0] fx_mul(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b,
                                                        inout bit ovf);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> Q_FRAC, ovf);
    endfunction

    // sum of w_i * x^i over n terms, w_i = c_i or (i+1)*c_(i+1)
    function automatic logic signed [DATA_W-1:0] term_sum(input logic signed [DATA_W-1:0] x,
                                                          input int n, input bit deriv,
                                                          inout bit ovf);
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] pw;
        logic signed [DATA_W-1:0] w;
        int i;
        acc = '0;
        pw = Q_ONE;
        for (i = 0; i < n; i++)
        begin
            if (deriv)
                w = clamp32(longint'(i + 1) * longint'(coef_mem[i + 1]), ovf);
            else
                w = coef_mem[i];
            acc = clamp32(longint'(acc) + longint'(fx_mul(pw, w, ovf)), ovf);
            // power only advanced when another term needs it
            if (i + 1 < n)
                pw = fx_mul(pw, x, ovf);
        end
        return acc;
    endfunction

    // expected answer for one command, updates the mirrored store
    function automatic result_t poly_answer(input cmd_t c);
        result_t r;
        bit      ovf;
        int      d;
        ovf = 1'b0;
        d = (deg_cfg > MAX_DEGREE) ? MAX_DEGREE : int'(deg_cfg);
        r.result_value = '0;
        r.status = ST_OK;
        case (c.command)
            CMD_LOAD:
            begin
                if (c.index > MAX_DEGREE)
                    r.status = ST_RANGE;
                else
                begin
                    coef_mem[c.index] = c.operand;
                    r.result_value = c.operand;
                end
            end
            CMD_EVAL:
            begin
                r.result_value = term_sum(c.operand, d + 1, 1'b0, ovf);
                r.status = ovf ? ST_SAT : ST_OK;
            end
            CMD_DERIV:
            begin
                r.result_value = term_sum(c.operand, d, 1'b1, ovf);
                r.status = ovf ? ST_SAT : ST_OK;
            end
            default:
            begin
                if (int'(c.index) > d)
                    r.status = ST_RANGE;
                else
                    r.result_value = coef_mem[c.index];
            end
        endcase
        return r;
    endfunction

    // coefficient values: mostly modest, some full range and extremes
    function automatic logic signed [DATA_W-1:0] coef_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return int'($urandom_range(0, 524288)) - 262144;
        if (r < 65)
            return (int'($urandom_range(0, 8)) - 4) * Q_ONE;
        if (r < 80)
            return $urandom;
        if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'shFFFF_FFFF;
                default: return 32'sh0000_0001;
            endcase
        end
        return '0;
    endfunction

    // evaluation points: mostly near the unit range so sums stay in bounds
    function automatic logic signed [DATA_W-1:0] point_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return int'($urandom_range(0, 196608)) - 98304;
        if (r < 70)
            return int'($urandom_range(0, 524288)) - 262144;
        if (r < 80)
            return $urandom;
        if (r < 90)
        begin
            case ($urandom_range(0, 2))
                0: return Q_ONE;
                1: return -Q_ONE;
                default: return '0;
            endcase
        end
        return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endfunction

    task automatic queue_cmd(input command_t op, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val);
        cmd_t c;
        c.command = op;
        c.index = idx;
        c.operand = val;
        pending_cmds.push_back(c);
    endtask

    // degree register write, only while the block is idle
    task automatic set_degree(input int deg);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= IDX_W'(deg);
        @(posedge clk);
        cfg_we <= 1'b0;
        deg_cfg = IDX_W'(deg);
        degrees_used[deg] = 1'b1;
    endtask

    // wait until every command is sent and answered
    task automatic drain();
        while (pending_cmds.size() != 0 || start || answers_due.size() != 0)
            @(negedge clk);
    endtask

    // coefficient loads followed by evaluations, plus some noise
    task automatic queue_random(input int target);
        int base;
        int n_load;
        int n_use;
        int k;
        base = pending_cmds.size();
        while (pending_cmds.size() - base < target)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                n_load = $urandom_range(1, int'(deg_cfg) + 1);
                for (k = 0; k < n_load; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        queue_cmd(CMD_LOAD, IDX_W'($urandom_range(0, 15)), coef_pick());
                    else if ($urandom_range(0, 1))
                        queue_cmd(CMD_LOAD, IDX_W'(k), coef_pick());
                    else
                        queue_cmd(CMD_LOAD, IDX_W'($urandom_range(0, deg_cfg)), coef_pick());
                end
                n_use = $urandom_range(1, 4);
                for (k = 0; k < n_use; k++)
                    queue_cmd($urandom_range(0, 1) ? CMD_EVAL : CMD_DERIV,
                              IDX_W'($urandom), point_pick());
                if ($urandom_range(0, 9) < 3)
                    queue_cmd(CMD_READ, IDX_W'($urandom_range(0, 15)), $urandom);
            end
            else
                queue_cmd(command_t'($urandom_range(0, 3)), IDX_W'($urandom), $urandom);
        end
    endtask

    // driver: predicts at each transfer, then offers the next command
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd_word <= '0;
            drain_hold = 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                next_answer = poly_answer(cmd_word);
                answers_due.push_back(next_answer);
                cmd_tally[cmd_word.command]++;
                if (next_answer.status == ST_SAT)
                    sat_tally++;
                if (next_answer.status == ST_RANGE)
                    range_tally++;
            end
            if (drain_hold && answers_due.size() == 0)
                drain_hold = 1'b0;
            if (!(start && busy))
            begin
                if (gaps_on && !drain_hold && pending_cmds.size() != 0
                    && $urandom_range(0, 99) < 2)
                    drain_hold = 1'b1;
                if (pending_cmds.size() != 0 && !drain_hold
                    && !(gaps_on && $urandom_range(0, 99) < 24))
                begin
                    cmd_word <= pending_cmds.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest answer due
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
                report_mismatch("result with no command outstanding");
            else
            begin
                got_answer = answers_due.pop_front();
                if (result_word.result_value !== got_answer.result_value)
                    report_mismatch($sformatf("result_value %h, expected %h",
                                              result_word.result_value,
                                              got_answer.result_value));
                if (result_word.status !== got_answer.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result_word.status, got_answer.status));
            end
        end
    end

    // run limit
    initial
    begin
        #12_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // stimulus
    initial
    begin
        int ph;
        int phase_deg[9];
        phase_deg = '{0, 15, 3, 7, 1, 15, 10, 2, 5};
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        deg_cfg = '0;
        gaps_on = 1'b1;
        degrees_used = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // constant polynomial, reads above degree
        set_degree(0);
        queue_cmd(CMD_DERIV, 4'd3, 5 * Q_ONE);
        queue_cmd(CMD_LOAD, 4'd0, 32'sh7FFF_FFFF);
        queue_cmd(CMD_EVAL, 4'd0, 32'sh8000_0000);
        queue_cmd(CMD_READ, 4'd0, '0);
        queue_cmd(CMD_READ, 4'd15, '0);
        queue_cmd(CMD_LOAD, 4'd15, 32'sh8000_0000);
        queue_cmd(CMD_READ, 4'd15, 32'shFFFF_FFFF);
        drain();

        // unused final power must not saturate
        set_degree(1);
        queue_cmd(CMD_LOAD, 4'd0, '0);
        queue_cmd(CMD_LOAD, 4'd1, Q_ONE);
        queue_cmd(CMD_EVAL, 4'd0, 32'sh7FFF_FFFF);
        queue_cmd(CMD_EVAL, 4'd0, 32'sh8000_0000);
        queue_cmd(CMD_DERIV, 4'd0, 32'sh7FFF_FFFF);
        queue_cmd(CMD_LOAD, 4'd1, 32'sh7FFF_FFFF);
        queue_cmd(CMD_DERIV, 4'd0, '0);
        drain();

        // full degree, saturation and negative rounding
        set_degree(15);
        queue_cmd(CMD_READ, 4'd15, '0);
        queue_cmd(CMD_EVAL, 4'd0, 2 * Q_ONE);
        queue_cmd(CMD_DERIV, 4'd0, Q_ONE);
        queue_cmd(CMD_LOAD, 4'd2, 32'shFFFF_FFFF);
        queue_cmd(CMD_EVAL, 4'd0, 32'shFFFF_FFFF);
        queue_cmd(CMD_READ, 4'd7, '0);
        queue_cmd(CMD_EVAL, 4'd15, '0);
        queue_cmd(CMD_DERIV, 4'd0, 32'sh8000_0000);
        drain();

        // random phases, one of them back to back
        for (ph = 0; ph < 9; ph++)
        begin
            gaps_on = (ph != 4);
            set_degree(phase_deg[ph]);
            queue_random(105);
            drain();
        end

        repeat (120) @(posedge clk);
        if (answers_due.size() != 0)
            report_mismatch("answers still due at end of run");
        $display("tb_top: %0d loads, %0d evaluations, %0d derivatives, %0d reads",
                 cmd_tally[CMD_LOAD], cmd_tally[CMD_EVAL], cmd_tally[CMD_DERIV],
                 cmd_tally[CMD_READ]);
        $display("tb_top: %0d saturated, %0d out of range, degrees used %b",
                 sat_tally, range_tally, degrees_used);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== polynomial_value_and_derivative_unit.f =====
design/polyvd_pkg.sv
design/polyvd_store.sv
design/polyvd_mul.sv
design/polynomial_value_and_derivative_unit.sv
test/tb_top.sv
